>>> rtl/core/sls_pkg.sv
// ----------------------------------------------------------------------------
// Sensor log statistics package
// Shared widths, reset levels, register indexes and divider status type.
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned LEVEL_W        = 15;
  localparam int unsigned SUM_W          = 31;
  localparam int unsigned STEP_W         = $clog2(SUM_W);
  localparam int unsigned OUT_CNT_W      = 16;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [LEVEL_W-1:0] WARNING_RST  = LEVEL_W'(480);
  localparam logic [LEVEL_W-1:0] CRITICAL_RST = LEVEL_W'(720);
  localparam logic [LEVEL_W-1:0] SHUTDOWN_RST = LEVEL_W'(960);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WARNING  = 2'd0,
    REG_CRITICAL = 2'd1,
    REG_SHUTDOWN = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/core/sls_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle, for the closing mean.
// ----------------------------------------------------------------------------
module sls_div
  import sls_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SUM_W-1:0]      dividend_i,
  input  logic [COUNT_BITS-1:0] divisor_i,
  output div_status_t           status_o,
  output logic [SUM_W-1:0]      quotient_o
);

  logic [SUM_W-1:0]      quo_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [COUNT_BITS-1:0] divisor_q;
  logic [STEP_W-1:0]     step_q;
  logic                  busy_q;
  logic                  done_q;

  logic [COUNT_BITS:0]   trial;
  logic                  ge;
  logic [COUNT_BITS:0]   diff;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = trial >= {1'b0, divisor_q};
  assign diff  = trial - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], ge};
      rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

>>> rtl/core/sensor_log_statistics_top.sv
// ----------------------------------------------------------------------------
// Sensor log statistics
// Running count, min, max, sum, band counters and first-critical index over
// a log of samples; one summary transaction with the mean per log.
//
//   channel   direction  handshake                  payload
//   cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//   in        in         in_valid_i / in_ready_o    sample_i, last_i
//   out       out        out_valid_o / out_ready_i  summary fields
//
// A sample without last leaves the block ready for the next one. A last sample
// passes through the serial divider (one quotient bit per cycle) and the finish
// state when the log holds positive samples, and goes straight to finish otherwise.
// Reset restores the level registers and clears all accumulators.
// The summary waits in the output register while out_ready_i is low; new
// samples are still taken then, and the next summary holds until it drains.
// ----------------------------------------------------------------------------
module sensor_log_statistics_top
  import sls_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEVEL_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_CNT_W-1:0] valid_count_o,
  output logic [OUT_CNT_W-1:0] skipped_count_o,
  output logic [LEVEL_W-1:0]   min_value_o,
  output logic [LEVEL_W-1:0]   max_value_o,
  output logic [LEVEL_W-1:0]   mean_value_o,
  output logic [OUT_CNT_W-1:0] first_critical_index_o,
  output logic [OUT_CNT_W-1:0] normal_count_o,
  output logic [OUT_CNT_W-1:0] warning_count_o,
  output logic [OUT_CNT_W-1:0] critical_count_o,
  output logic [OUT_CNT_W-1:0] shutdown_count_o,
  output logic                 none_valid_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  logic [1:0]            state_q, state_d;
  logic [LEVEL_W-1:0]    warn_q, crit_q, shut_q;
  logic [COUNT_BITS-1:0] cnt_valid_q, cnt_valid_d;
  logic [COUNT_BITS-1:0] cnt_skip_q, cnt_skip_d;
  logic [LEVEL_W-1:0]    min_q, min_d;
  logic [LEVEL_W-1:0]    max_q, max_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [COUNT_BITS-1:0] hot_q, hot_d;
  logic [COUNT_BITS-1:0] band_q [4];
  logic [COUNT_BITS-1:0] band_d [4];
  logic                  div_start_q;
  logic                  out_valid_q;

  logic                  in_fire;
  logic                  positive;
  logic [LEVEL_W-1:0]    s;
  logic [SUM_W:0]        sum_ext;
  logic [3:0]            band_sel;
  logic                  out_free;
  logic                  none;
  logic [SUM_W-1:0]      quotient;
  logic [LEVEL_W-1:0]    mean;
  div_status_t           div_stat;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign positive = (sample_i != '0) && !sample_i[SAMPLE_W-1];
  assign s        = sample_i[LEVEL_W-1:0];
  assign sum_ext  = {1'b0, sum_q} + (SUM_W+1)'(s);

  always_comb begin
    band_sel = 4'b0000;
    if (s < warn_q) begin
      band_sel[0] = 1'b1;
    end else if (s < crit_q) begin
      band_sel[1] = 1'b1;
    end else if (s < shut_q) begin
      band_sel[2] = 1'b1;
    end else begin
      band_sel[3] = 1'b1;
    end
  end

  always_comb begin
    cnt_valid_d = cnt_valid_q;
    cnt_skip_d  = cnt_skip_q;
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    hot_d       = hot_q;
    for (int b = 0; b < 4; b++) begin
      band_d[b] = band_q[b];
    end
    if (positive) begin
      cnt_valid_d = sat_inc(cnt_valid_q);
      if (s < min_q) begin
        min_d = s;
      end
      if (s > max_q) begin
        max_d = s;
      end
      sum_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      if ((hot_q == '0) && (s > crit_q)) begin
        hot_d = cnt_valid_d;
      end
      for (int b = 0; b < 4; b++) begin
        if (band_sel[b]) begin
          band_d[b] = sat_inc(band_q[b]);
        end
      end
    end else begin
      cnt_skip_d = sat_inc(cnt_skip_q);
    end
  end

  assign none = (cnt_valid_q == '0);
  assign mean = none ? '0 :
                (quotient[SUM_W-1:LEVEL_W] != '0) ? '1 : quotient[LEVEL_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && last_i) begin
          state_d = (cnt_valid_d == '0) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_q <= WARNING_RST;
      crit_q <= CRITICAL_RST;
      shut_q <= SHUTDOWN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WARNING:  warn_q <= cfg_data_i;
        REG_CRITICAL: crit_q <= cfg_data_i;
        REG_SHUTDOWN: shut_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_valid_q <= '0;
      cnt_skip_q  <= '0;
      min_q       <= '1;
      max_q       <= '0;
      sum_q       <= '0;
      hot_q       <= '0;
      for (int b = 0; b < 4; b++) begin
        band_q[b] <= '0;
      end
    end else begin
      state_q     <= state_d;
      div_start_q <= (state_q == ST_IDLE) && (state_d == ST_DIV);
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        cnt_valid_q <= cnt_valid_d;
        cnt_skip_q  <= cnt_skip_d;
        min_q       <= min_d;
        max_q       <= max_d;
        sum_q       <= sum_d;
        hot_q       <= hot_d;
        for (int b = 0; b < 4; b++) begin
          band_q[b] <= band_d[b];
        end
      end else if ((state_q == ST_FIN) && out_free) begin
        cnt_valid_q <= '0;
        cnt_skip_q  <= '0;
        min_q       <= '1;
        max_q       <= '0;
        sum_q       <= '0;
        hot_q       <= '0;
        for (int b = 0; b < 4; b++) begin
          band_q[b] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FIN) && out_free) begin
      valid_count_o          <= OUT_CNT_W'(cnt_valid_q);
      skipped_count_o        <= OUT_CNT_W'(cnt_skip_q);
      min_value_o            <= none ? '0 : min_q;
      max_value_o            <= none ? '0 : max_q;
      mean_value_o           <= mean;
      first_critical_index_o <= OUT_CNT_W'(hot_q);
      normal_count_o         <= OUT_CNT_W'(band_q[0]);
      warning_count_o        <= OUT_CNT_W'(band_q[1]);
      critical_count_o       <= OUT_CNT_W'(band_q[2]);
      shutdown_count_o       <= OUT_CNT_W'(band_q[3]);
      none_valid_o           <= none;
    end
  end

  assign out_valid_o = out_valid_q;

  sls_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (sum_q),
    .divisor_i  (cnt_valid_q),
    .status_o   (div_stat),
    .quotient_o (quotient)
  );

  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_i) |=> !in_ready_o)
    else $error("input taken right after a closing sample");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.busy || div_stat.done) |-> (state_q == ST_DIV))
    else $error("divider active outside the divide phase");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && none_valid_o) |->
      (mean_value_o == '0 && min_value_o == '0 && max_value_o == '0))
    else $error("empty log summary carries nonzero statistics");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !none_valid_o) |-> (min_value_o <= max_value_o))
    else $error("summary minimum above maximum");

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor log statistics testbench
// Feeds sample logs through the input channel with random idle cycles on both
// sides and predicts each per-log summary in a behavioral tally. Each summary
// transaction is checked field by field against the oldest prediction. The
// run covers:
//   - band edges and sample extremes;
//   - empty logs;
//   - misordered and extreme levels, and an ignored register write;
//   - one stretch of logs with no idle cycles on either side;
//   - random logs under changing levels and output back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import sls_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS_DEF) - 1;
  localparam logic [31:0] SUM_SAT = 32'h7FFF_FFFF;
  localparam int unsigned MEAN_MAX = 32767;
  localparam int BAND_NORMAL = 0;
  localparam int BAND_WARNING = 1;
  localparam int BAND_CRITICAL = 2;
  localparam int BAND_SHUTDOWN = 3;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [SAMPLE_W-1:0] reading;
    logic                is_last;
  } reading_t;

  typedef struct {
    logic [OUT_CNT_W-1:0] valid_count;
    logic [OUT_CNT_W-1:0] skipped_count;
    logic [LEVEL_W-1:0]   min_value;
    logic [LEVEL_W-1:0]   max_value;
    logic [LEVEL_W-1:0]   mean_value;
    logic [OUT_CNT_W-1:0] first_critical_index;
    logic [OUT_CNT_W-1:0] normal_count;
    logic [OUT_CNT_W-1:0] warning_count;
    logic [OUT_CNT_W-1:0] critical_count;
    logic [OUT_CNT_W-1:0] shutdown_count;
    logic                 none_valid;
  } summary_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [LEVEL_W-1:0]   cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [SAMPLE_W-1:0]  sample_i = '0;
  logic                 last_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [OUT_CNT_W-1:0] valid_count_o;
  logic [OUT_CNT_W-1:0] skipped_count_o;
  logic [LEVEL_W-1:0]   min_value_o;
  logic [LEVEL_W-1:0]   max_value_o;
  logic [LEVEL_W-1:0]   mean_value_o;
  logic [OUT_CNT_W-1:0] first_critical_index_o;
  logic [OUT_CNT_W-1:0] normal_count_o;
  logic [OUT_CNT_W-1:0] warning_count_o;
  logic [OUT_CNT_W-1:0] critical_count_o;
  logic [OUT_CNT_W-1:0] shutdown_count_o;
  logic                 none_valid_o;

  reading_t reading_q[$];
  summary_t summary_q[$];
  int       errors = 0;
  int       idle_pct = 32;
  int       hold_off_req = 0;
  int       hold_left = 0;
  logic     in_taken = 1'b0;

  logic [LEVEL_W-1:0] warn_lvl = WARNING_RST;
  logic [LEVEL_W-1:0] crit_lvl = CRITICAL_RST;
  logic [LEVEL_W-1:0] shut_lvl = SHUTDOWN_RST;

  longint unsigned    n_valid = 0;
  longint unsigned    n_skipped = 0;
  longint unsigned    hot_idx = 0;
  longint unsigned    band_n[4] = '{default: 0};
  logic [LEVEL_W-1:0] lo_val = '1;
  logic [LEVEL_W-1:0] hi_val = '0;
  logic [31:0]        sum_acc = '0;

  sensor_log_statistics_top dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .sample_i              (sample_i),
    .last_i                (last_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .valid_count_o         (valid_count_o),
    .skipped_count_o       (skipped_count_o),
    .min_value_o           (min_value_o),
    .max_value_o           (max_value_o),
    .mean_value_o          (mean_value_o),
    .first_critical_index_o(first_critical_index_o),
    .normal_count_o        (normal_count_o),
    .warning_count_o       (warning_count_o),
    .critical_count_o      (critical_count_o),
    .shutdown_count_o      (shutdown_count_o),
    .none_valid_o          (none_valid_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint unsigned bump(input longint unsigned v);
    return (v < CNT_MAX) ? v + 1 : v;
  endfunction

  task automatic log_sample(input logic [SAMPLE_W-1:0] raw, input logic is_last);
    logic [LEVEL_W-1:0] s;
    logic [31:0]        wide;
    longint unsigned    avg;
    summary_t           res;
    s = raw[LEVEL_W-1:0];
    if (raw != '0 && !raw[SAMPLE_W-1]) begin
      n_valid = bump(n_valid);
      if (s < lo_val) lo_val = s;
      if (s > hi_val) hi_val = s;
      wide = sum_acc + 32'(s);
      sum_acc = (wide > SUM_SAT) ? SUM_SAT : wide;
      if (hot_idx == 0 && s > crit_lvl) hot_idx = n_valid;
      if (s < warn_lvl) begin
        band_n[BAND_NORMAL] = bump(band_n[BAND_NORMAL]);
      end else if (s < crit_lvl) begin
        band_n[BAND_WARNING] = bump(band_n[BAND_WARNING]);
      end else if (s < shut_lvl) begin
        band_n[BAND_CRITICAL] = bump(band_n[BAND_CRITICAL]);
      end else begin
        band_n[BAND_SHUTDOWN] = bump(band_n[BAND_SHUTDOWN]);
      end
    end else begin
      n_skipped = bump(n_skipped);
    end
    if (is_last) begin
      avg = 0;
      if (n_valid != 0) begin
        avg = longint'(sum_acc) / n_valid;
        if (avg > MEAN_MAX) avg = MEAN_MAX;
      end
      res.valid_count          = OUT_CNT_W'(n_valid);
      res.skipped_count        = OUT_CNT_W'(n_skipped);
      res.min_value            = (n_valid == 0) ? '0 : lo_val;
      res.max_value            = (n_valid == 0) ? '0 : hi_val;
      res.mean_value           = LEVEL_W'(avg);
      res.first_critical_index = OUT_CNT_W'(hot_idx);
      res.normal_count         = OUT_CNT_W'(band_n[BAND_NORMAL]);
      res.warning_count        = OUT_CNT_W'(band_n[BAND_WARNING]);
      res.critical_count       = OUT_CNT_W'(band_n[BAND_CRITICAL]);
      res.shutdown_count       = OUT_CNT_W'(band_n[BAND_SHUTDOWN]);
      res.none_valid           = (n_valid == 0);
      summary_q.push_back(res);
      n_valid = 0;
      n_skipped = 0;
      hot_idx = 0;
      foreach (band_n[i]) band_n[i] = 0;
      lo_val = '1;
      hi_val = '0;
      sum_acc = '0;
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Track level writes and check summaries before predicting the new sample.
  always @(posedge clk_i) begin : score
    summary_t want;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WARNING:  warn_lvl = cfg_data_i;
        REG_CRITICAL: crit_lvl = cfg_data_i;
        REG_SHUTDOWN: shut_lvl = cfg_data_i;
        default: ;
      endcase
    end
    if (out_valid_o && out_ready_i) begin
      if (summary_q.size() == 0) begin
        $display("%0t summary transaction: expected none, actual one", $time);
        errors++;
      end else begin
        want = summary_q.pop_front();
        check_field("valid_count", want.valid_count, valid_count_o);
        check_field("skipped_count", want.skipped_count, skipped_count_o);
        check_field("min_value", want.min_value, min_value_o);
        check_field("max_value", want.max_value, max_value_o);
        check_field("mean_value", want.mean_value, mean_value_o);
        check_field("first_critical_index", want.first_critical_index,
                    first_critical_index_o);
        check_field("normal_count", want.normal_count, normal_count_o);
        check_field("warning_count", want.warning_count, warning_count_o);
        check_field("critical_count", want.critical_count, critical_count_o);
        check_field("shutdown_count", want.shutdown_count, shutdown_count_o);
        check_field("none_valid", want.none_valid, none_valid_o);
      end
    end
    in_taken = in_valid_i && in_ready_o;
    if (in_taken) log_sample(sample_i, last_i);
  end

  always @(negedge clk_i) begin : drive
    reading_t nxt;
    if (!in_valid_i || in_taken) begin
      if (reading_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = reading_q.pop_front();
        sample_i <= nxt.reading;
        last_i <= nxt.is_last;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left == 0 && hold_off_req != 0) begin
      hold_left = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic void add(input logic [SAMPLE_W-1:0] s, input logic l);
    reading_q.push_back('{reading: s, is_last: l});
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int lvl;
    case ($urandom_range(9))
      0: return SAMPLE_W'($urandom);
      1: return -SAMPLE_W'($urandom_range(32768));
      2, 3: begin
        case ($urandom_range(2))
          0: lvl = int'(warn_lvl);
          1: lvl = int'(crit_lvl);
          default: lvl = int'(shut_lvl);
        endcase
        lvl = lvl + int'($urandom_range(4)) - 2;
        if (lvl < 0) lvl = 0;
        if (lvl > 32767) lvl = 32767;
        return SAMPLE_W'(lvl);
      end
      4: return $urandom_range(1) ? SAMPLE_W'(1) : SAMPLE_W'(32767);
      default: return SAMPLE_W'($urandom_range(1200, 1));
    endcase
  endfunction

  function automatic int random_log();
    int len;
    len = ($urandom_range(7) == 0) ? $urandom_range(60, 11) : $urandom_range(10, 1);
    for (int i = 0; i < len; i++) add(pick_sample(), i == len - 1);
    return len;
  endfunction

  function automatic int edge_level();
    case ($urandom_range(3))
      0: return 0;
      1: return 32767;
      default: return $urandom_range(32767);
    endcase
  endfunction

  task automatic set_level(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= LEVEL_W'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_levels();
    int a, b, c;
    if ($urandom_range(9) < 7) begin
      a = $urandom_range(1000, 1);
      b = a + $urandom_range(500);
      c = b + $urandom_range(500);
    end else begin
      a = edge_level();
      b = edge_level();
      c = edge_level();
    end
    if ($urandom_range(3) == 0) set_level(REG_NONE, $urandom);
    set_level(REG_WARNING, a);
    set_level(REG_CRITICAL, b);
    set_level(REG_SHUTDOWN, c);
  endtask

  // Hold until every prediction is met and the divider has settled.
  task automatic drain();
    while (reading_q.size() != 0 || in_valid_i || summary_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int added;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add(16'd1, 1'b0);
    add(16'd479, 1'b0);
    add(16'd480, 1'b0);
    add(16'd719, 1'b0);
    add(16'd720, 1'b0);
    add(16'd721, 1'b0);
    add(16'd959, 1'b0);
    add(16'd960, 1'b0);
    add(16'h7FFF, 1'b0);
    add(16'h0000, 1'b0);
    add(16'hFFFF, 1'b0);
    add(16'h8000, 1'b0);
    add(16'd500, 1'b1);
    add(16'h0000, 1'b0);
    add(16'h8000, 1'b1);
    add(16'd720, 1'b1);
    add(16'h0000, 1'b1);
    drain();

    set_level(REG_NONE, 5);
    add(16'd480, 1'b1);
    drain();

    set_level(REG_WARNING, 900);
    set_level(REG_CRITICAL, 600);
    set_level(REG_SHUTDOWN, 300);
    add(16'd100, 1'b0);
    add(16'd400, 1'b0);
    add(16'd700, 1'b0);
    add(16'd950, 1'b1);
    drain();

    set_level(REG_WARNING, 0);
    set_level(REG_CRITICAL, 0);
    set_level(REG_SHUTDOWN, 0);
    add(16'd1, 1'b0);
    add(16'h7FFF, 1'b1);
    drain();

    set_level(REG_WARNING, 32767);
    set_level(REG_CRITICAL, 32767);
    set_level(REG_SHUTDOWN, 32767);
    add(16'd32766, 1'b0);
    add(16'h7FFF, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      idle_pct = (p == 1) ? 0 : 32;
      random_levels();
      if (p == 3) hold_off_req = HOLD_CYCLES;
      added = 0;
      while (added < 125) added += random_log();
      drain();
    end

    if (summary_q.size() != 0) begin
      $display("%0t pending summaries: expected 0, actual %0d", $time,
               summary_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
